// ===== hw/rtl/qru_pkg.sv =====
// ----------------------------------------------------------------------------
// qru_pkg
// Shared widths, request codes and fixed-point helpers for the quaternion
// rotation unit.
// ----------------------------------------------------------------------------
package qru_pkg;

  localparam int unsigned QUAT_FRAC_BITS = 30;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned NUM_IN   = 7;
  localparam int unsigned NUM_OUT  = 3;
  localparam int unsigned S_DATA_W = NUM_IN * FIELD_W;
  localparam int unsigned M_DATA_W = NUM_OUT * FIELD_W;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_USER_W = 3;

  // quaternion part after the conjugate may reach +2^31
  localparam int unsigned QW  = FIELD_W + 1;
  // first product, rounded product / t / matrix entry
  localparam int unsigned PBW = 2 * QW;
  localparam int unsigned CW  = PBW - QUAT_FRAC_BITS;
  // second product, its rounded value, final sum
  localparam int unsigned DW  = QW + CW;
  localparam int unsigned EW  = DW - QUAT_FRAC_BITS;
  localparam int unsigned SW  = EW + 2;

  localparam int unsigned RND_HALF = 1 << (QUAT_FRAC_BITS - 1);

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  // cross product index pairs
  localparam int unsigned IDX_A [3] = '{1, 2, 0};
  localparam int unsigned IDX_B [3] = '{2, 0, 1};

  typedef enum logic {
    REQ_ROTATE = 1'b0,
    REQ_MATRIX = 1'b1
  } req_t;

  typedef struct packed {
    logic              clip;
    logic [FIELD_W-1:0] val;
  } sat_t;

  // round to nearest, ties away from zero, then drop the fraction bits
  function automatic logic signed [CW-1:0] rnd_p(input logic signed [PBW-1:0] p);
    logic [PBW-1:0] s;
    s = p + PBW'(RND_HALF) - PBW'(p[PBW-1]);
    return s[PBW-1:QUAT_FRAC_BITS];
  endfunction

  function automatic logic signed [EW-1:0] rnd_d(input logic signed [DW-1:0] p);
    logic [DW-1:0] s;
    s = p + DW'(RND_HALF) - DW'(p[DW-1]);
    return s[DW-1:QUAT_FRAC_BITS];
  endfunction

  function automatic sat_t sat_c(input logic signed [CW-1:0] v);
    sat_t r;
    r.clip = !((&v[CW-1:FIELD_W-1]) || !(|v[CW-1:FIELD_W-1]));
    r.val  = r.clip ? {v[CW-1], {(FIELD_W-1){!v[CW-1]}}} : v[FIELD_W-1:0];
    return r;
  endfunction

  function automatic sat_t sat_s(input logic signed [SW-1:0] v);
    sat_t r;
    r.clip = !((&v[SW-1:FIELD_W-1]) || !(|v[SW-1:FIELD_W-1]));
    r.val  = r.clip ? {v[SW-1], {(FIELD_W-1){!v[SW-1]}}} : v[FIELD_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/quaternion_rotation_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotation_unit
// Rotates a Q16.16 vector by a Q1.30 quaternion, or emits the three rows of
// the quaternion's rotation matrix, in a six stage pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser / tlast
//  s_*     | in  | quat_w, quat_x, quat_y, quat_z, vec_x..vec_z | req_type, inverse
//  m_*     | out | out_x, out_y, out_z                          | row_index, saturated / last
//
//  a request passes through the stage registers a, b, c, d, e and f in that order
//  rotate requests flow at one per cycle while m_tready is high; a matrix request
//  holds the output register until its three rows are taken, one row per beat
//  reset clears the stage valid bits and the row counter
//  each stage loads only when it is empty or its successor takes its content,
//  so a stall on m_tready backs up stage by stage without losing requests
// ----------------------------------------------------------------------------
module quaternion_rotation_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
  input  logic [qru_pkg::S_DATA_W-1:0] s_tdata,
  // req_type, inverse
  input  logic [qru_pkg::S_USER_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_x, out_y, out_z
  output logic [qru_pkg::M_DATA_W-1:0] m_tdata,
  // row_index (2 bits), saturated
  output logic [qru_pkg::M_USER_W-1:0] m_tuser,
  output logic                         m_tlast
);

  localparam int unsigned FW  = qru_pkg::FIELD_W;
  localparam int unsigned QW  = qru_pkg::QW;
  localparam int unsigned PBW = qru_pkg::PBW;
  localparam int unsigned CW  = qru_pkg::CW;
  localparam int unsigned DW  = qru_pkg::DW;
  localparam int unsigned EW  = qru_pkg::EW;
  localparam int unsigned SW  = qru_pkg::SW;

  // stage valids and load enables
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld;
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_f;

  // stage a: registered request, conjugate applied when inverse is set
  qru_pkg::req_t         a_req;
  logic signed [QW-1:0]  a_w;
  logic signed [QW-1:0]  a_q [3];
  logic signed [FW-1:0]  a_v [3];

  // stage b: raw first products
  qru_pkg::req_t         b_req;
  logic signed [QW-1:0]  b_w;
  logic signed [QW-1:0]  b_q [3];
  logic signed [FW-1:0]  b_v [3];
  logic signed [PBW-1:0] b_prod [10];
  logic signed [PBW-1:0] b_prod_next [10];
  logic signed [QW-1:0]  op1 [10];
  logic signed [QW-1:0]  op2 [10];

  // stage c: t vector or matrix entries
  qru_pkg::req_t         c_req;
  logic signed [QW-1:0]  c_w;
  logic signed [QW-1:0]  c_q [3];
  logic signed [FW-1:0]  c_v [3];
  logic signed [CW-1:0]  c_val [9];
  logic signed [CW-1:0]  c_val_next [9];
  logic signed [CW-1:0]  rr [10];

  // stage d: raw second products
  qru_pkg::req_t         d_req;
  logic signed [FW-1:0]  d_v [3];
  logic signed [CW-1:0]  d_val [9];
  logic signed [DW-1:0]  d_prod [9];
  logic signed [DW-1:0]  d_prod_next [9];

  // stage e: rounded second products
  qru_pkg::req_t         e_req;
  logic signed [FW-1:0]  e_v [3];
  logic signed [CW-1:0]  e_val [9];
  logic signed [EW-1:0]  e_rnd [9];

  // stage f: output register, one row per beat
  qru_pkg::req_t         f_req;
  logic [FW*3-1:0]       f_row [3];
  logic                  f_sat [3];
  logic [FW*3-1:0]       f_row_next [3];
  logic                  f_sat_next [3];
  logic [1:0]            f_cnt;

  qru_pkg::sat_t         sr;
  logic signed [SW-1:0]  sum;
  logic                  any_clip;

  assign ld_f     = !f_vld || (m_tready && m_tlast);
  assign ld_e     = !e_vld || ld_f;
  assign ld_d     = !d_vld || ld_e;
  assign ld_c     = !c_vld || ld_d;
  assign ld_b     = !b_vld || ld_c;
  assign ld_a     = !a_vld || ld_b;
  assign s_tready = ld_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      f_cnt <= qru_pkg::ROW_FIRST;
    end else begin
      if (ld_a) a_vld <= s_tvalid;
      if (ld_b) b_vld <= a_vld;
      if (ld_c) c_vld <= b_vld;
      if (ld_d) d_vld <= c_vld;
      if (ld_e) e_vld <= d_vld;
      if (ld_f) f_vld <= e_vld;
      if (f_vld && m_tready) begin
        if (m_tlast) begin
          f_cnt <= qru_pkg::ROW_FIRST;
        end else begin
          f_cnt <= f_cnt + 2'd1;
        end
      end
    end
  end

  // operand select: cross product terms for rotate, the ten products for matrix
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      op1[i] = a_q[0];
      op2[i] = a_q[0];
    end
    if (a_req == qru_pkg::REQ_ROTATE) begin
      for (int i = 0; i < 3; i++) begin
        op1[2*i]   = a_q[qru_pkg::IDX_A[i]];
        op2[2*i]   = QW'(a_v[qru_pkg::IDX_B[i]]);
        op1[2*i+1] = a_q[qru_pkg::IDX_B[i]];
        op2[2*i+1] = QW'(a_v[qru_pkg::IDX_A[i]]);
      end
    end else begin
      op1[0] = a_w;    op2[0] = a_w;
      op1[1] = a_q[0]; op2[1] = a_q[0];
      op1[2] = a_q[1]; op2[2] = a_q[1];
      op1[3] = a_q[2]; op2[3] = a_q[2];
      op1[4] = a_q[0]; op2[4] = a_q[1];
      op1[5] = a_q[0]; op2[5] = a_q[2];
      op1[6] = a_q[1]; op2[6] = a_q[2];
      op1[7] = a_w;    op2[7] = a_q[0];
      op1[8] = a_w;    op2[8] = a_q[1];
      op1[9] = a_w;    op2[9] = a_q[2];
    end
    for (int i = 0; i < 10; i++) begin
      b_prod_next[i] = op1[i] * op2[i];
    end
  end

  // products order for matrix: ww xx yy zz xy xz yz wx wy wz
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      rr[i] = qru_pkg::rnd_p(b_prod[i]);
    end
    for (int i = 0; i < 9; i++) begin
      c_val_next[i] = '0;
    end
    if (b_req == qru_pkg::REQ_ROTATE) begin
      for (int i = 0; i < 3; i++) begin
        c_val_next[i] = (rr[2*i] - rr[2*i+1]) <<< 1;
      end
    end else begin
      c_val_next[0] = rr[0] + rr[1] - rr[2] - rr[3];
      c_val_next[1] = (rr[4] - rr[9]) <<< 1;
      c_val_next[2] = (rr[5] + rr[8]) <<< 1;
      c_val_next[3] = (rr[4] + rr[9]) <<< 1;
      c_val_next[4] = rr[0] - rr[1] + rr[2] - rr[3];
      c_val_next[5] = (rr[6] - rr[7]) <<< 1;
      c_val_next[6] = (rr[5] - rr[8]) <<< 1;
      c_val_next[7] = (rr[6] + rr[7]) <<< 1;
      c_val_next[8] = rr[0] - rr[1] - rr[2] + rr[3];
    end
  end

  // q x t and w*t terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_prod_next[3*i]   = c_q[qru_pkg::IDX_A[i]] * c_val[qru_pkg::IDX_B[i]];
      d_prod_next[3*i+1] = c_q[qru_pkg::IDX_B[i]] * c_val[qru_pkg::IDX_A[i]];
      d_prod_next[3*i+2] = c_w * c_val[i];
    end
  end

  always_comb begin
    any_clip = 1'b0;
    sum      = '0;
    sr       = '0;
    for (int k = 0; k < 3; k++) begin
      f_row_next[k] = '0;
      f_sat_next[k] = 1'b0;
    end
    if (e_req == qru_pkg::REQ_ROTATE) begin
      for (int i = 0; i < 3; i++) begin
        sum = SW'(e_v[i]) + SW'(e_rnd[3*i]) - SW'(e_rnd[3*i+1]) + SW'(e_rnd[3*i+2]);
        sr  = qru_pkg::sat_s(sum);
        f_row_next[0][FW*i +: FW] = sr.val;
        any_clip = any_clip | sr.clip;
      end
      f_sat_next[0] = any_clip;
    end else begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          sr = qru_pkg::sat_c(e_val[3*k+i]);
          f_row_next[k][FW*i +: FW] = sr.val;
          f_sat_next[k] = f_sat_next[k] | sr.clip;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_req <= qru_pkg::req_t'(s_tuser[0]);
      a_w   <= QW'($signed(s_tdata[0 +: FW]));
      for (int i = 0; i < 3; i++) begin
        if (s_tuser[1]) begin
          a_q[i] <= -QW'($signed(s_tdata[FW*(i+1) +: FW]));
        end else begin
          a_q[i] <= QW'($signed(s_tdata[FW*(i+1) +: FW]));
        end
        a_v[i] <= s_tdata[FW*(i+4) +: FW];
      end
    end
    if (ld_b) begin
      b_req <= a_req;
      b_w   <= a_w;
      b_q   <= a_q;
      b_v   <= a_v;
      b_prod <= b_prod_next;
    end
    if (ld_c) begin
      c_req <= b_req;
      c_w   <= b_w;
      c_q   <= b_q;
      c_v   <= b_v;
      c_val <= c_val_next;
    end
    if (ld_d) begin
      d_req  <= c_req;
      d_v    <= c_v;
      d_val  <= c_val;
      d_prod <= d_prod_next;
    end
    if (ld_e) begin
      e_req <= d_req;
      e_v   <= d_v;
      e_val <= d_val;
      for (int i = 0; i < 9; i++) begin
        e_rnd[i] <= qru_pkg::rnd_d(d_prod[i]);
      end
    end
    if (ld_f) begin
      f_req <= e_req;
      f_row <= f_row_next;
      f_sat <= f_sat_next;
    end
  end

  assign m_tvalid = f_vld;
  assign m_tdata  = f_row[f_cnt];
  assign m_tuser  = {f_sat[f_cnt], f_cnt};
  assign m_tlast  = (f_req == qru_pkg::REQ_ROTATE) || (f_cnt == qru_pkg::ROW_LAST);

  // input backs up only when every stage holds a request
  ast_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (a_vld && b_vld && c_vld && d_vld && e_vld && f_vld))
    else $error("input stalled with an empty stage");

  ast_row_hold: assert property (@(posedge clk) disable iff (rst)
    (f_vld && !m_tready) |=> (f_cnt == $past(f_cnt)))
    else $error("row counter moved during output stall");

  ast_rotate_single_row: assert property (@(posedge clk) disable iff (rst)
    (f_vld && f_req == qru_pkg::REQ_ROTATE) |-> (f_cnt == qru_pkg::ROW_FIRST))
    else $error("rotate result on a row other than the first");

endmodule
